// ===== hw/rtl/hlc_pkg.sv =====
// Shared types, constants and helpers of the homogeneous line clipper.
package hlc_pkg;

  // Crossing parameter t has T_BITS fraction bits and one integer bit
  localparam int T_BITS = 30;
  localparam int Q_W    = T_BITS + 1;

  // Screen coordinate format
  localparam int SCR_FRAC = 4;
  localparam int SCR_W    = 17;
  localparam logic [SCR_W-1:0] SCR_MAX = {SCR_W{1'b1}};

  // Window register widths
  localparam int ORG_W  = 12;
  localparam int SIZE_W = 13;
  localparam int CFG_IDX_W = 3;

  // Numerator of the screen division: offset (33 bits) * size * 2^SCR_FRAC
  localparam int NUM_W = 33 + SIZE_W + SCR_FRAC;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

  typedef logic signed [31:0] coord_t;

  // One segment: index 0..3 is x, y, z, w
  typedef struct packed {
    coord_t [3:0] a;
    coord_t [3:0] b;
  } seg_t;

  // Control that travels with each pipeline slot
  typedef struct packed {
    logic vld;
    logic dead;
  } ctl_t;

  typedef enum logic [2:0] {
    PL_XNEG = 3'd0,
    PL_XPOS = 3'd1,
    PL_YNEG = 3'd2,
    PL_YPOS = 3'd3,
    PL_ZNEG = 3'd4,
    PL_ZPOS = 3'd5
  } plane_e;

  // Signed distance of a point to a plane; negative means outside
  function automatic logic signed [33:0] plane_dist(plane_e p, coord_t [3:0] v);
    logic signed [33:0] x, y, z, w, r;
    x = 34'($signed(v[0]));
    y = 34'($signed(v[1]));
    z = 34'($signed(v[2]));
    w = 34'($signed(v[3]));
    unique case (p)
      PL_XNEG: r = w + x;
      PL_XPOS: r = w - x;
      PL_YNEG: r = w + y;
      PL_YPOS: r = w - y;
      PL_ZNEG: r = z;
      PL_ZPOS: r = w - z;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/hlc_plane.sv =====
// Pipelined clip of a segment against one frustum plane.
module hlc_plane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  hlc_pkg::plane_e plane_i,
  input  hlc_pkg::ctl_t   in_ctl_i,
  input  hlc_pkg::seg_t   in_seg_i,
  output hlc_pkg::ctl_t   out_ctl_o,
  output hlc_pkg::seg_t   out_seg_o
);
  import hlc_pkg::*;

  // Distance stage
  ctl_t        ds_ctl_d, ds_ctl_q;
  seg_t        ds_seg_q;
  logic        ds_cut_d, ds_cut_q;
  logic        ds_alo_d, ds_alo_q;
  logic [32:0] ds_ma_d, ds_ma_q;
  logic [33:0] ds_den_d, ds_den_q;

  always_comb begin
    logic signed [33:0] da, db;
    logic [33:0] ua, ub;
    da = plane_dist(plane_i, in_seg_i.a);
    db = plane_dist(plane_i, in_seg_i.b);
    ua = da[33] ? 34'(-da) : 34'(da);
    ub = db[33] ? 34'(-db) : 34'(db);
    ds_ctl_d.vld  = in_ctl_i.vld;
    ds_ctl_d.dead = in_ctl_i.dead | (da[33] & db[33]);
    ds_cut_d = da[33] ^ db[33];
    ds_alo_d = da[33];
    ds_ma_d  = ua[32:0];
    ds_den_d = {1'b0, ua[32:0]} + {1'b0, ub[32:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_ctl_q <= '0;
    end else if (en_i) begin
      ds_ctl_q <= ds_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_seg_q <= in_seg_i;
      ds_cut_q <= ds_cut_d;
      ds_alo_q <= ds_alo_d;
      ds_ma_q  <= ds_ma_d;
      ds_den_q <= ds_den_d;
    end
  end

  // Restoring division t = ma * 2^T_BITS / (ma + mb), one quotient bit per stage
  ctl_t           dv_ctl_q [T_BITS+1];
  seg_t           dv_seg_q [T_BITS+1];
  logic           dv_cut_q [T_BITS+1];
  logic           dv_alo_q [T_BITS+1];
  logic [33:0]    dv_r_q   [T_BITS+1];
  logic [33:0]    dv_den_q [T_BITS+1];
  logic [Q_W-1:0] dv_t_q   [T_BITS+1];

  // Integer bit: set only when the far distance is zero
  logic        dv0_ge;
  logic [33:0] dv0_r;
  assign dv0_ge = {1'b0, ds_ma_q} >= ds_den_q;
  assign dv0_r  = dv0_ge ? ({1'b0, ds_ma_q} - ds_den_q) : {1'b0, ds_ma_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctl_q[0] <= '0;
    end else if (en_i) begin
      dv_ctl_q[0] <= ds_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_seg_q[0] <= ds_seg_q;
      dv_cut_q[0] <= ds_cut_q;
      dv_alo_q[0] <= ds_alo_q;
      dv_r_q[0]   <= dv0_r;
      dv_den_q[0] <= ds_den_q;
      dv_t_q[0]   <= {{(Q_W-1){1'b0}}, dv0_ge};
    end
  end

  for (genvar k = 1; k <= T_BITS; k++) begin : g_div
    logic [34:0] r2;
    logic        ge;
    logic [33:0] rn;
    assign r2 = {dv_r_q[k-1], 1'b0};
    assign ge = r2 >= {1'b0, dv_den_q[k-1]};
    assign rn = ge ? 34'(r2 - {1'b0, dv_den_q[k-1]}) : r2[33:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_ctl_q[k] <= '0;
      end else if (en_i) begin
        dv_ctl_q[k] <= dv_ctl_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_seg_q[k] <= dv_seg_q[k-1];
        dv_cut_q[k] <= dv_cut_q[k-1];
        dv_alo_q[k] <= dv_alo_q[k-1];
        dv_r_q[k]   <= rn;
        dv_den_q[k] <= dv_den_q[k-1];
        dv_t_q[k]   <= {dv_t_q[k-1][Q_W-2:0], ge};
      end
    end
  end

  // Differences b - a
  ctl_t               m1_ctl_q;
  seg_t               m1_seg_q;
  logic               m1_cut_q, m1_alo_q;
  logic [Q_W-1:0]     m1_t_q;
  logic signed [32:0] m1_diff_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_ctl_q <= '0;
    end else if (en_i) begin
      m1_ctl_q <= dv_ctl_q[T_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_seg_q <= dv_seg_q[T_BITS];
      m1_cut_q <= dv_cut_q[T_BITS];
      m1_alo_q <= dv_alo_q[T_BITS];
      m1_t_q   <= dv_t_q[T_BITS];
      for (int i = 0; i < 4; i++) begin
        m1_diff_q[i] <= 33'($signed(dv_seg_q[T_BITS].b[i]))
                      - 33'($signed(dv_seg_q[T_BITS].a[i]));
      end
    end
  end

  // Partial products of diff * t, split at bit 16 of t
  ctl_t               m2_ctl_q;
  seg_t               m2_seg_q;
  logic               m2_cut_q, m2_alo_q;
  logic signed [49:0] m2_pl_q [4];
  logic signed [48:0] m2_ph_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_ctl_q <= '0;
    end else if (en_i) begin
      m2_ctl_q <= m1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_seg_q <= m1_seg_q;
      m2_cut_q <= m1_cut_q;
      m2_alo_q <= m1_alo_q;
      for (int i = 0; i < 4; i++) begin
        m2_pl_q[i] <= m1_diff_q[i] * $signed({1'b0, m1_t_q[15:0]});
        m2_ph_q[i] <= m1_diff_q[i] * $signed({1'b0, m1_t_q[Q_W-1:16]});
      end
    end
  end

  // Combine, truncate toward zero, move the outside endpoint
  ctl_t m3_ctl_q;
  seg_t m3_seg_d, m3_seg_q;

  always_comb begin
    logic signed [64:0] prod;
    logic signed [64:0] adj;
    logic signed [64:0] sh;
    coord_t             p;
    m3_seg_d = m2_seg_q;
    for (int i = 0; i < 4; i++) begin
      prod = $signed({m2_ph_q[i], 16'b0}) + 65'(m2_pl_q[i]);
      adj  = prod[64] ? (prod + 65'sd1073741823) : prod;
      sh   = adj >>> T_BITS;
      p    = coord_t'(m2_seg_q.a[i] + sh[31:0]);
      if (m2_cut_q) begin
        if (m2_alo_q) begin
          m3_seg_d.a[i] = p;
        end else begin
          m3_seg_d.b[i] = p;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_ctl_q <= '0;
    end else if (en_i) begin
      m3_ctl_q <= m2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_seg_q <= m3_seg_d;
    end
  end

  assign out_ctl_o = m3_ctl_q;
  assign out_seg_o = m3_seg_q;

endmodule

// ===== hw/rtl/hlc_map.sv =====
// Perspective divide and viewport mapping of both endpoints, pipelined.
module hlc_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  hlc_pkg::ctl_t                 in_ctl_i,
  input  hlc_pkg::seg_t                 in_seg_i,
  input  logic [hlc_pkg::ORG_W-1:0]     left_i,
  input  logic [hlc_pkg::ORG_W-1:0]     top_i,
  input  logic [hlc_pkg::SIZE_W-1:0]    width_i,
  input  logic [hlc_pkg::SIZE_W-1:0]    height_i,
  output logic                          valid_o,
  output logic                          visible_o,
  output logic [hlc_pkg::SCR_W-1:0]     coord_o [4]
);
  import hlc_pkg::*;

  // Lane 0/1: start x/y, lane 2/3: end x/y
  logic             sa_vld_q, sa_ok_q;
  logic [NUM_W-1:0] sa_num_q [4];
  logic [32:0]      sa_den_q [4];

  logic             sa_ok_d;
  logic [NUM_W-1:0] sa_num_d [4];
  logic [32:0]      sa_den_d [4];

  always_comb begin
    logic signed [32:0] off;
    logic signed [32:0] xs, ys, ws;
    logic [SIZE_W-1:0]  size;
    logic [45:0]        prod;
    logic [31:0]        w;
    sa_ok_d = in_ctl_i.vld & ~in_ctl_i.dead
            & ~in_seg_i.a[3][31] & (in_seg_i.a[3] != '0)
            & ~in_seg_i.b[3][31] & (in_seg_i.b[3] != '0);
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        xs = 33'($signed(in_seg_i.a[0]));
        ys = 33'($signed(in_seg_i.a[1]));
        ws = 33'($signed(in_seg_i.a[3]));
        w  = in_seg_i.a[3];
      end else begin
        xs = 33'($signed(in_seg_i.b[0]));
        ys = 33'($signed(in_seg_i.b[1]));
        ws = 33'($signed(in_seg_i.b[3]));
        w  = in_seg_i.b[3];
      end
      off  = (l % 2 == 0) ? (ws + xs) : (ws - ys);
      size = (l % 2 == 0) ? width_i : height_i;
      prod = 46'(off[32:0]) * 46'(size);
      if (!off[32] && (off != '0)) begin
        sa_num_d[l] = {prod, {SCR_FRAC{1'b0}}};
      end else begin
        sa_num_d[l] = '0;
      end
      sa_den_d[l] = {w, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en_i) begin
      sa_vld_q <= in_ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_ok_q <= sa_ok_d;
      for (int l = 0; l < 4; l++) begin
        sa_num_q[l] <= sa_num_d[l];
        sa_den_q[l] <= sa_den_d[l];
      end
    end
  end

  // Quotient floor(num / den), SCR_W bits plus overflow, one bit per stage
  logic             dq_vld_q [SCR_W+1];
  logic             dq_ok_q  [SCR_W+1];
  logic [3:0]       dq_ovf_q [SCR_W+1];
  logic [NUM_W-1:0] dq_num_q [SCR_W+1][4];
  logic [32:0]      dq_den_q [SCR_W+1][4];
  logic [32:0]      dq_r_q   [SCR_W+1][4];
  logic [SCR_W-1:0] dq_q_q   [SCR_W+1][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dq_vld_q[0] <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_ok_q[0] <= sa_ok_q;
      for (int l = 0; l < 4; l++) begin
        dq_ovf_q[0][l] <= sa_num_q[l] >= {sa_den_q[l], {SCR_W{1'b0}}};
        dq_num_q[0][l] <= sa_num_q[l];
        dq_den_q[0][l] <= sa_den_q[l];
        dq_r_q[0][l]   <= sa_num_q[l][NUM_W-1:SCR_W];
        dq_q_q[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= SCR_W; j++) begin : g_div
    localparam int Bit = SCR_W - j;
    logic [33:0] r2 [4];
    logic        ge [4];
    logic [32:0] rn [4];

    // Shift in the next numerator bit and try to subtract
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        r2[l] = {dq_r_q[j-1][l], dq_num_q[j-1][l][Bit]};
        ge[l] = r2[l] >= {1'b0, dq_den_q[j-1][l]};
        rn[l] = ge[l] ? 33'(r2[l] - {1'b0, dq_den_q[j-1][l]}) : r2[l][32:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dq_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        dq_vld_q[j] <= dq_vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_ok_q[j]  <= dq_ok_q[j-1];
        dq_ovf_q[j] <= dq_ovf_q[j-1];
        for (int l = 0; l < 4; l++) begin
          dq_r_q[j][l]   <= rn[l];
          dq_q_q[j][l]   <= {dq_q_q[j-1][l][SCR_W-2:0], ge[l]};
          dq_num_q[j][l] <= dq_num_q[j-1][l];
          dq_den_q[j][l] <= dq_den_q[j-1][l];
        end
      end
    end
  end

  // Add window origin, saturate, zero hidden segments
  logic             out_vld_q, out_vis_q;
  logic [SCR_W-1:0] out_c_d [4];
  logic [SCR_W-1:0] out_c_q [4];

  always_comb begin
    logic [SCR_W-1:0] qs;
    logic [SCR_W:0]   sum;
    logic [ORG_W-1:0] org;
    for (int l = 0; l < 4; l++) begin
      org = (l % 2 == 0) ? left_i : top_i;
      qs  = dq_ovf_q[SCR_W][l] ? SCR_MAX : dq_q_q[SCR_W][l];
      sum = (SCR_W+1)'({org, {SCR_FRAC{1'b0}}}) + (SCR_W+1)'(qs);
      if (!dq_ok_q[SCR_W]) begin
        out_c_d[l] = '0;
      end else if (sum > (SCR_W+1)'(SCR_MAX)) begin
        out_c_d[l] = SCR_MAX;
      end else begin
        out_c_d[l] = sum[SCR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= dq_vld_q[SCR_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_vis_q <= dq_ok_q[SCR_W];
      for (int l = 0; l < 4; l++) begin
        out_c_q[l] <= out_c_d[l];
      end
    end
  end

  assign valid_o   = out_vld_q;
  assign visible_o = out_vis_q;
  assign coord_o   = out_c_q;

endmodule

// ===== hw/rtl/homogeneous_line_clip_to_screen.sv =====
// Top level of the homogeneous line clipper with viewport mapping.
//
// Takes one segment per cycle while the output is not stalled and returns one
// result per segment, in order. Each segment passes six plane clippers
// (x >= -w, x <= w, y >= -w, y <= w, z >= 0, z <= w), then the screen
// mapper. Most of the pipeline depth lies in the bit-serial dividers: 31
// stages for the crossing parameter in every plane clipper and 18 for the
// perspective divide. The whole pipeline holds while a result waits on the
// output and the sink is not ready. Window registers must be written only
// while no segment is in flight; the block itself does not enforce this.
module homogeneous_line_clip_to_screen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hlc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hlc_pkg::SIZE_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w
  input  logic [255:0]                    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // screen_start_x, screen_start_y, screen_end_x, screen_end_y, 4 pad bits
  output logic [71:0]                     m_axis_tdata,
  // visible
  output logic                            m_axis_tuser
);
  import hlc_pkg::*;

  // Window registers
  logic [ORG_W-1:0]  left_q, top_q;
  logic [SIZE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= SIZE_W'(1920);
      height_q <= SIZE_W'(1080);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT:   left_q   <= cfg_data_i[ORG_W-1:0];
        REG_TOP:    top_q    <= cfg_data_i[ORG_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds a waiting result
  logic en;
  assign en = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // Unpack the input transfer
  ctl_t pl_ctl [7];
  seg_t pl_seg [7];

  always_comb begin
    pl_ctl[0].vld  = s_axis_tvalid;
    pl_ctl[0].dead = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pl_seg[0].a[i] = s_axis_tdata[32*i +: 32];
      pl_seg[0].b[i] = s_axis_tdata[128 + 32*i +: 32];
    end
  end

  // Clip against the planes in fixed order
  plane_e plane_sel [6];
  assign plane_sel[0] = PL_XNEG;
  assign plane_sel[1] = PL_XPOS;
  assign plane_sel[2] = PL_YNEG;
  assign plane_sel[3] = PL_YPOS;
  assign plane_sel[4] = PL_ZNEG;
  assign plane_sel[5] = PL_ZPOS;

  for (genvar p = 0; p < 6; p++) begin : g_plane
    hlc_plane u_plane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .plane_i   (plane_sel[p]),
      .in_ctl_i  (pl_ctl[p]),
      .in_seg_i  (pl_seg[p]),
      .out_ctl_o (pl_ctl[p+1]),
      .out_seg_o (pl_seg[p+1])
    );
  end

  // Map to the window
  logic [SCR_W-1:0] coord [4];

  hlc_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_ctl_i  (pl_ctl[6]),
    .in_seg_i  (pl_seg[6]),
    .left_i    (left_q),
    .top_i     (top_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .valid_o   (m_axis_tvalid),
    .visible_o (m_axis_tuser),
    .coord_o   (coord)
  );

  assign m_axis_tdata = {4'b0, coord[3], coord[2], coord[1], coord[0]};

endmodule
